// ===== rtl/gpfa_pkg.sv =====
// gpfa_pkg: payload types and fixed widths of the pairwise gravity force core
// no dependencies

package gpfa_pkg;

    localparam int POSITION_BITS = 20;
    localparam int MASS_BITS     = 8;
    localparam int FORCE_BITS    = 32;
    localparam int GAIN_BITS     = 32;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 32'd16777216;

    typedef struct packed {
        logic        [POSITION_BITS-1:0] first_x;
        logic        [POSITION_BITS-1:0] first_y;
        logic        [POSITION_BITS-1:0] second_x;
        logic        [POSITION_BITS-1:0] second_y;
        logic        [MASS_BITS-1:0]     first_mass;
        logic        [MASS_BITS-1:0]     second_mass;
        logic signed [FORCE_BITS-1:0]    force_in_x;
        logic signed [FORCE_BITS-1:0]    force_in_y;
    } t_in;

    typedef struct packed {
        logic signed [FORCE_BITS-1:0] force_out_x;
        logic signed [FORCE_BITS-1:0] force_out_y;
        logic                         coincident;
    } t_out;

endpackage

// ===== rtl/gravity_pair_force_accumulate_core.sv =====
// gravity_pair_force_accumulate_core: pairwise gravity force added to a running force
// one pair accepted every cycle
// the square root takes one bit per stage, the two divisions one quotient bit per stage
// synchronous active-low reset clears the valid bits and sets the gain to 1.0
// busy stays low: results leave on o_valid for one cycle and cannot be held off
// depends on gpfa_pkg

module gravity_pair_force_accumulate_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  gpfa_pkg::t_in                  i_in,
    output logic                           o_valid,
    output gpfa_pkg::t_out                 o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gpfa_pkg::GAIN_BITS-1:0] i_cfg_data
);
    import gpfa_pkg::*;

    localparam int W   = POSITION_BITS;
    localparam int D2W = 2 * W + 1;
    localparam int SW  = W + 1;
    localparam int SQW = 2 * SW;
    localparam int MW  = 2 * MASS_BITS;
    localparam int GMW = GAIN_BITS + 7;
    localparam int KW  = GMW + MW;
    localparam int NW  = KW + W;
    localparam int DW  = D2W + SW;
    localparam int QB  = 33;
    localparam int CW  = DW + QB;
    localparam int NST = SW + QB + 5;
    localparam logic [QB-1:0] MAG_MAX = QB'(1) << (QB - 1);

    typedef struct packed {
        logic signed [FORCE_BITS-1:0] fx;
        logic signed [FORCE_BITS-1:0] fy;
        logic                         nx;
        logic                         ny;
    } t_side;

    logic [GAIN_BITS-1:0] r_gain;
    logic [NST-1:0]       r_vld;

    // stage 1
    logic [W-1:0]   r1_ax, r1_ay, n1_ax, n1_ay;
    logic [MW-1:0]  r1_m;
    logic [GMW-1:0] r1_gm;
    t_side          r1_side, n1_side;

    // square root stages
    logic [D2W-1:0] r_d2   [0:SW];
    logic [KW-1:0]  r_k    [0:SW];
    logic [W-1:0]   r_ax   [0:SW];
    logic [W-1:0]   r_ay   [0:SW];
    t_side          r_side [0:SW];
    logic [SW-1:0]  r_r    [0:SW];
    logic [SQW-1:0] r_sq   [0:SW];

    // multiply stage
    logic [DW-1:0]  r_mden;
    logic [NW-1:0]  r_mnx, r_mny;
    logic           r_mzero;
    t_side          r_mside;

    // division stages
    logic [CW-1:0]  r_remx [0:QB];
    logic [CW-1:0]  r_remy [0:QB];
    logic [QB-1:0]  r_qx   [0:QB];
    logic [QB-1:0]  r_qy   [0:QB];
    logic [DW-1:0]  r_den  [0:QB];
    logic           r_ovx  [0:QB];
    logic           r_ovy  [0:QB];
    logic           r_zero [0:QB];
    t_side          r_dside[0:QB];

    t_out           r_out, n_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = ~|r_vld;
    assign o_valid     = r_vld[NST-1];
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_vld  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain <= i_cfg_data;
            end
            r_vld <= {r_vld[NST-2:0], start && !busy};
        end
    end

    always_comb begin
        n1_side.nx = i_in.second_x < i_in.first_x;
        n1_side.ny = i_in.second_y < i_in.first_y;
        n1_side.fx = i_in.force_in_x;
        n1_side.fy = i_in.force_in_y;
        n1_ax = n1_side.nx ? i_in.first_x - i_in.second_x : i_in.second_x - i_in.first_x;
        n1_ay = n1_side.ny ? i_in.first_y - i_in.second_y : i_in.second_y - i_in.first_y;
    end

    always_ff @(posedge i_clk) begin
        r1_ax   <= n1_ax;
        r1_ay   <= n1_ay;
        r1_side <= n1_side;
        r1_m    <= MW'(i_in.first_mass) * MW'(i_in.second_mass);
        r1_gm   <= GMW'(r_gain) * GMW'(100);
    end

    // stage 2: squared distance and mass-gain product
    always_ff @(posedge i_clk) begin
        r_d2[0]   <= D2W'(r1_ax) * D2W'(r1_ax) + D2W'(r1_ay) * D2W'(r1_ay);
        r_k[0]    <= KW'(r1_gm) * KW'(r1_m);
        r_ax[0]   <= r1_ax;
        r_ay[0]   <= r1_ay;
        r_side[0] <= r1_side;
        r_r[0]    <= '0;
        r_sq[0]   <= '0;
    end

    // digit-by-digit square root, one bit per stage
    for (genvar j = 0; j < SW; j++) begin : g_sqrt
        localparam int B = SW - 1 - j;
        logic [SQW:0] t;
        logic         take;
        assign t = (SQW+1)'(r_sq[j]) + ((SQW+1)'(r_r[j]) << (B + 1))
                 + ((SQW+1)'(1) << (2 * B));
        assign take = (SQW+1)'(r_d2[j]) >= t;
        always_ff @(posedge i_clk) begin
            r_d2[j+1]   <= r_d2[j];
            r_k[j+1]    <= r_k[j];
            r_ax[j+1]   <= r_ax[j];
            r_ay[j+1]   <= r_ay[j];
            r_side[j+1] <= r_side[j];
            r_r[j+1]    <= take ? (r_r[j] | (SW'(1) << B)) : r_r[j];
            r_sq[j+1]   <= take ? t[SQW-1:0] : r_sq[j];
        end
    end

    // denominator and numerators
    always_ff @(posedge i_clk) begin
        r_mden  <= DW'(r_d2[SW]) * DW'(r_r[SW]);
        r_mnx   <= NW'(r_k[SW]) * NW'(r_ax[SW]);
        r_mny   <= NW'(r_k[SW]) * NW'(r_ay[SW]);
        r_mzero <= r_d2[SW] == '0;
        r_mside <= r_side[SW];
    end

    // quotient range check and divider setup
    always_ff @(posedge i_clk) begin
        r_remx[0]  <= CW'(r_mnx);
        r_remy[0]  <= CW'(r_mny);
        r_qx[0]    <= '0;
        r_qy[0]    <= '0;
        r_den[0]   <= r_mden;
        r_ovx[0]   <= CW'(r_mnx) >= (CW'(r_mden) << QB);
        r_ovy[0]   <= CW'(r_mny) >= (CW'(r_mden) << QB);
        r_zero[0]  <= r_mzero;
        r_dside[0] <= r_mside;
    end

    // restoring division, one quotient bit per stage for each axis
    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        logic [CW-1:0] dsh;
        logic          tx, ty;
        assign dsh = CW'(r_den[j]) << B;
        assign tx  = r_remx[j] >= dsh;
        assign ty  = r_remy[j] >= dsh;
        always_ff @(posedge i_clk) begin
            r_remx[j+1]  <= tx ? r_remx[j] - dsh : r_remx[j];
            r_remy[j+1]  <= ty ? r_remy[j] - dsh : r_remy[j];
            r_qx[j+1]    <= tx ? (r_qx[j] | (QB'(1) << B)) : r_qx[j];
            r_qy[j+1]    <= ty ? (r_qy[j] | (QB'(1) << B)) : r_qy[j];
            r_den[j+1]   <= r_den[j];
            r_ovx[j+1]   <= r_ovx[j];
            r_ovy[j+1]   <= r_ovy[j];
            r_zero[j+1]  <= r_zero[j];
            r_dside[j+1] <= r_dside[j];
        end
    end

    function automatic logic [QB-1:0] clamp_mag(logic ov, logic zero, logic [QB-1:0] q);
        logic [QB-1:0] m;
        m = (ov || q > MAG_MAX) ? MAG_MAX : q;
        return zero ? '0 : m;
    endfunction

    function automatic logic [FORCE_BITS-1:0] sat_add(logic [FORCE_BITS-1:0] f, logic neg,
                                                       logic [QB-1:0] mag);
        logic signed [FORCE_BITS+1:0] e;
        logic signed [FORCE_BITS+1:0] mg;
        logic signed [FORCE_BITS+1:0] s;
        e  = (FORCE_BITS+2)'(signed'(f));
        mg = signed'((FORCE_BITS+2)'(mag));
        s  = neg ? e - mg : e + mg;
        if (s > signed'((FORCE_BITS+2)'(32'h7fffffff))) begin
            return 32'h7fffffff;
        end else if (s < -signed'((FORCE_BITS+2)'(32'h80000000))) begin
            return 32'h80000000;
        end else begin
            return s[FORCE_BITS-1:0];
        end
    endfunction

    always_comb begin
        n_out.force_out_x = sat_add(r_dside[QB].fx, r_dside[QB].nx,
                                    clamp_mag(r_ovx[QB], r_zero[QB], r_qx[QB]));
        n_out.force_out_y = sat_add(r_dside[QB].fy, r_dside[QB].ny,
                                    clamp_mag(r_ovy[QB], r_zero[QB], r_qy[QB]));
        n_out.coincident  = r_zero[QB];
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef ASSERT_OFF
    a_result_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, NST))
        else $error("result without a start beat");

    a_sqrt_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SW+1] |-> (SQW'(r_r[SW]) * SQW'(r_r[SW]) <= SQW'(r_d2[SW])))
        else $error("square root too large");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SW+3+QB] && !r_ovx[QB] && !r_zero[QB] |-> r_remx[QB] < CW'(r_den[QB]))
        else $error("division remainder not below divisor");

    a_coincident_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-2] && r_zero[QB] |=> o_out.force_out_x == $past(r_dside[QB].fx)
            && o_out.force_out_y == $past(r_dside[QB].fy))
        else $error("coincident pair changed the force");
`endif

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for gravity_pair_force_accumulate_core
// queue-fed driver, clocked monitor, bit-exact force predictor
// depends on gpfa_pkg and the core
`timescale 1ns / 100ps

module tb_top;
    import gpfa_pkg::*;

    localparam int LATENCY   = POSITION_BITS + 39;
    localparam int MAX_CYCLE = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  i_in = '0;
    logic o_valid;
    t_out o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [GAIN_BITS-1:0] i_cfg_data = '0;

    gravity_pair_force_accumulate_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_valid(o_valid), .o_out(o_out), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_in  pair_q[$];
    t_out force_q[$];
    logic [GAIN_BITS-1:0] gain_model;
    int   n_bad = 0;
    int   cycle = 0;
    int   gap = 0;
    logic hold = 1'b0;

    // exact gravity contribution on one axis, clamped to 2^32
    function automatic logic [32:0] axis_mag(logic [127:0] k, logic [127:0] a,
                                             logic [127:0] den);
        logic [127:0] q;
        q = (k * a) / den;
        return (q > 128'h1_0000_0000) ? 33'h1_0000_0000 : q[32:0];
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] f, logic neg,
                                                   logic [32:0] mag);
        logic signed [65:0] s;
        s = neg ? 66'(f) - $signed({33'd0, mag}) : 66'(f) + $signed({33'd0, mag});
        if (s > 66'sd2147483647) return 32'sh7fffffff;
        if (s < -66'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic t_out pair_force(t_in p, logic [31:0] gain);
        t_out r;
        logic nx, ny;
        logic [127:0] ax, ay, d2, s, k, den;
        logic [32:0] mx, my;
        nx = p.second_x < p.first_x;
        ny = p.second_y < p.first_y;
        ax = nx ? p.first_x - p.second_x : p.second_x - p.first_x;
        ay = ny ? p.first_y - p.second_y : p.second_y - p.first_y;
        d2 = ax * ax + ay * ay;
        mx = 0;
        my = 0;
        if (d2 != 0) begin
            s = 0;
            for (int b = 34; b >= 0; b--)
                if (((s | (128'd1 << b)) * (s | (128'd1 << b))) <= d2) s |= 128'd1 << b;
            den = d2 * s;
            k = 128'(gain) * 100 * p.first_mass * p.second_mass;
            mx = axis_mag(k, ax, den);
            my = axis_mag(k, ay, den);
        end
        r.force_out_x = sat_add(p.force_in_x, nx, mx);
        r.force_out_y = sat_add(p.force_in_y, ny, my);
        r.coincident = (d2 == 0);
        return r;
    endfunction

    function automatic logic [19:0] rnd_pos();
        case ($urandom_range(0, 3))
            0: return 20'($urandom_range(0, 4));
            1: return 20'hfffff - 20'($urandom_range(0, 4));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic t_in rnd_pair();
        t_in p;
        p.first_x = rnd_pos();
        p.first_y = rnd_pos();
        p.second_x = ($urandom_range(0, 7) == 0) ? p.first_x : rnd_pos();
        p.second_y = ($urandom_range(0, 7) == 0) ? p.first_y : rnd_pos();
        if ($urandom_range(0, 2) == 0) begin
            p.second_x = p.first_x + 20'($urandom_range(0, 600)) - 20'd300;
            p.second_y = p.first_y + 20'($urandom_range(0, 600)) - 20'd300;
        end
        p.first_mass = 8'($urandom_range(1, 255));
        p.second_mass = 8'($urandom_range(1, 255));
        p.force_in_x = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 2000)) - 1000
                                                     : 32'($urandom);
        p.force_in_y = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 2000)) - 1000
                                                     : 32'($urandom);
        return p;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (start && !busy) begin
            force_q.push_back(pair_force(i_in, gain_model));
            void'(pair_q.pop_front());
            gap = $urandom_range(0, 4);
        end
        if (!start || !busy) begin
            if (!hold && pair_q.size() > 0 && !(start && !busy ? gap > 0 : gap > 0)) begin
                start <= 1'b1;
                i_in <= (start && !busy) ? pair_q[0] : pair_q[0];
            end else begin
                start <= 1'b0;
                if (gap > 0 && !(start && !busy)) gap = gap - 1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("tb_top: FAIL");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (force_q.size() == 0) begin
                n_bad = n_bad + 1;
                if (n_bad <= 10) $display("unexpected beat %h", o_out);
            end else begin
                if (o_out.force_out_x !== force_q[0].force_out_x ||
                    o_out.force_out_y !== force_q[0].force_out_y ||
                    o_out.coincident !== force_q[0].coincident) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("mismatch exp %h got %h", force_q[0], o_out);
                end
                void'(force_q.pop_front());
            end
        end
    end

    task automatic wait_drained();
        while (pair_q.size() > 0 || start || force_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_gain(logic [31:0] g);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        gain_model = g;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_in p;
        logic [31:0] gains[6];
        gain_model = GAIN_RESET;
        hold = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed pairs at reset gain
        p = '0; p.first_mass = 1; p.second_mass = 1; pair_q.push_back(p);
        p.force_in_x = 32'sh7fffffff; p.force_in_y = 32'sh80000000; pair_q.push_back(p);
        p = '1; pair_q.push_back(p);
        p.second_x = 0; p.second_y = 0; pair_q.push_back(p);
        p = '0; p.first_mass = 255; p.second_mass = 255; p.second_x = 1;
        p.force_in_x = 32'sh7fffff00; pair_q.push_back(p);
        p.second_x = 0; p.first_x = 1; p.second_y = 1;
        p.force_in_x = 32'sh80000100; pair_q.push_back(p);
        p = '0; p.first_x = 20'hfffff; p.second_y = 20'hfffff;
        p.first_mass = 1; p.second_mass = 1; pair_q.push_back(p);
        p.first_mass = 8'h80; p.second_mass = 8'h7f; p.force_in_x = 32'h55555555;
        p.force_in_y = 32'haaaaaaaa; pair_q.push_back(p);
        hold = 1'b0;
        wait_drained();
        gains = '{32'hffffffff, 32'd0, 32'd1, 32'h00400000, 32'h0a000000, GAIN_RESET};
        for (int g = 0; g < 6; g++) begin
            repeat (LATENCY + 4) @(posedge i_clk);
            set_gain(gains[g]);
            for (int i = 0; i < 75; i++) pair_q.push_back(rnd_pair());
            if (g == 2) begin
                // sender holds off until the pipe is empty
                while (pair_q.size() > 40) @(posedge i_clk);
                hold = 1'b1;
                while (start || force_q.size() > 0) @(posedge i_clk);
                hold = 1'b0;
            end
            wait_drained();
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_bad == 0 && force_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
